/* src/knn_pkg.sv */
package knn_pkg;

  localparam int COMP_W    = 16;
  localparam int INDEX_W   = 20;
  localparam int DIST_W    = 42;
  localparam int K_COUNT_W = 5;
  localparam int DIM_W     = 11;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int QDEPTH    = 4;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [DIST_W-1:0]    DIST_MAX      = '1;
  localparam logic [K_COUNT_W-1:0] K_COUNT_RESET = 5'd1;
  localparam logic [DIM_W-1:0]     DIM_RESET     = 11'd128;

  localparam logic REG_K_COUNT = 1'b0;
  localparam logic REG_DIM     = 1'b1;

  typedef struct packed {
    logic [K_COUNT_W-1:0] k_count;
    logic [DIM_W-1:0]     dim;
  } knn_cfg_t;

  typedef struct packed {
    logic close;
    logic last;
  } knn_flags_t;

endpackage

/* src/knn_ram.sv */
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/knn_fifo.sv */
module knn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 rdata,
  output logic                             empty,
  output logic [$clog2(DEPTH + 1)-1:0]     count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  assign rdata = slots[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

/* src/knn_front.sv */
module knn_front #(
  parameter int DIM_MAX        = 1024,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  knn_pkg::knn_cfg_t                 cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic signed [knn_pkg::COMP_W-1:0] component,
  input  logic                              last_in_set,
  input  logic [knn_pkg::QCNT_W-1:0]        queue_count,
  output logic                              push,
  output logic [2*COMPONENT_BITS-1:0]       push_sq,
  output knn_pkg::knn_flags_t               push_flags
);

  import knn_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int DW = ($clog2(DIM_MAX + 1) > DIM_W) ? $clog2(DIM_MAX + 1) : DIM_W;

  logic [AW-1:0]     pos;
  logic [AW-1:0]     pos_next;
  logic [DW-1:0]     d_eff;
  logic [DW-1:0]     pos_inc;
  logic              vec_end;
  logic              accept;
  logic [CB-1:0]     comp_raw;
  logic [CB-1:0]     q_data;
  logic              a_valid;
  logic [CB-1:0]     a_comp;
  knn_flags_t        a_flags;
  logic signed [CB:0] diff;
  logic [CB-1:0]     mag;
  logic              b_valid;
  logic [2*CB-1:0]   b_sq;
  knn_flags_t        b_flags;
  logic [QCNT_W:0]   used;

  assign comp_raw = CB'($unsigned(component));
  assign used     = (QCNT_W+1)'(queue_count) + (QCNT_W+1)'(a_valid) + (QCNT_W+1)'(b_valid);
  assign in_ready = used < (QCNT_W+1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    priority if (cfg.dim == '0) begin
      d_eff = DW'(1);
    end else if (DW'(cfg.dim) > DW'(DIM_MAX)) begin
      d_eff = DW'(DIM_MAX);
    end else begin
      d_eff = DW'(cfg.dim);
    end
  end

  assign pos_inc = DW'(pos) + DW'(1);
  assign vec_end = pos_inc >= d_eff;

  always_comb begin
    pos_next = pos;
    if (accept) begin
      pos_next = (vec_end || (mode && last_in_set)) ? '0 : AW'(pos_inc);
    end
  end

  knn_ram #(
    .WIDTH (CB),
    .DEPTH (DIM_MAX)
  ) u_qram (
    .clk   (clk),
    .we    (accept && !mode),
    .waddr (pos),
    .wdata (comp_raw),
    .raddr (pos),
    .rdata (q_data)
  );

  assign diff = $signed({a_comp[CB-1], a_comp}) - $signed({q_data[CB-1], q_data});
  assign mag  = diff[CB] ? CB'(-diff) : CB'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      pos     <= pos_next;
      a_valid <= accept && mode;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_comp        <= comp_raw;
      a_flags.close <= vec_end || last_in_set;
      a_flags.last  <= last_in_set;
    end
    b_sq    <= (2*CB)'(mag) * (2*CB)'(mag);
    b_flags <= a_flags;
  end

  assign push       = b_valid;
  assign push_sq    = b_sq;
  assign push_flags = b_flags;

endmodule

/* src/knn_back.sv */
module knn_back #(
  parameter int K_MAX          = 16,
  parameter int BASE_MAX       = 1048576,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  knn_pkg::knn_cfg_t              cfg,
  input  logic                           q_empty,
  input  logic [2*COMPONENT_BITS-1:0]    q_sq,
  input  knn_pkg::knn_flags_t            q_flags,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [knn_pkg::INDEX_W-1:0]    neighbor_index,
  output logic [knn_pkg::DIST_W-1:0]     distance,
  output logic                           last_result,
  output logic                           overflow
);

  import knn_pkg::*;

  localparam int CB  = COMPONENT_BITS;
  localparam int SW  = ((2*CB > DIST_W) ? 2*CB : DIST_W) + 1;
  localparam int BW  = $clog2(BASE_MAX + 1);
  localparam int IW  = $clog2(BASE_MAX);
  localparam int KW  = $clog2(K_MAX + 1);
  localparam int EW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KCW = (KW > K_COUNT_W) ? KW : K_COUNT_W;

  logic [DIST_W-1:0] acc;
  logic [SW-1:0]     sum;
  logic [DIST_W-1:0] sat_dist;
  logic [BW-1:0]     base_cnt;
  logic              at_cap;
  logic              overflow_seen;

  logic              cand_valid;
  logic              cand_ins;
  logic              cand_last;
  logic              cand_ovf;
  logic [DIST_W-1:0] cand_dist;
  logic [IW-1:0]     cand_idx;

  logic [DIST_W-1:0] list_dist [K_MAX];
  logic [IW-1:0]     list_idx  [K_MAX];
  logic [KW-1:0]     held;
  logic [KW-1:0]     keff;
  logic [KW-1:0]     ins_pos;
  logic [KW-1:0]     emit_cnt;
  logic [K_MAX-1:0]  gt;
  logic [K_MAX-1:0]  below_held;
  logic [K_MAX-1:0]  g;
  logic              held_lt_k;
  logic              do_ins;

  logic              emitting;
  logic              emit_ovf;
  logic [EW-1:0]     emit_pos;
  logic              emit_last;
  logic              busy;
  logic              out_load;

  assign busy = emitting || (cand_valid && cand_last);
  assign pop  = !q_empty && !busy;

  assign sum      = SW'(acc) + SW'(q_sq);
  assign sat_dist = (sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
  assign at_cap   = base_cnt >= BW'(BASE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      base_cnt      <= '0;
      overflow_seen <= 1'b0;
      cand_valid    <= 1'b0;
    end else begin
      cand_valid <= pop && q_flags.close;
      if (pop) begin
        if (q_flags.close) begin
          acc <= '0;
          if (q_flags.last) begin
            base_cnt      <= '0;
            overflow_seen <= 1'b0;
          end else if (at_cap) begin
            overflow_seen <= 1'b1;
          end else begin
            base_cnt <= base_cnt + BW'(1);
          end
        end else begin
          acc <= sat_dist;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cand_ins  <= !at_cap;
      cand_last <= q_flags.last;
      cand_ovf  <= overflow_seen || at_cap;
      cand_dist <= sat_dist;
      cand_idx  <= IW'(base_cnt);
    end
  end

  always_comb begin
    priority if (cfg.k_count == '0) begin
      keff = KW'(1);
    end else if (KCW'(cfg.k_count) > KCW'(K_MAX)) begin
      keff = KW'(K_MAX);
    end else begin
      keff = KW'(cfg.k_count);
    end
  end

  assign held_lt_k = held < keff;
  assign ins_pos   = held_lt_k ? held : held - KW'(1);
  assign emit_cnt  = held_lt_k ? held : keff;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    assign gt[i]         = list_dist[i] > cand_dist;
    assign below_held[i] = KW'(i) < held;
    assign g[i]          = gt[i] && (KW'(i) < ins_pos);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_ins && ((ins_pos == '0) || g[0])) begin
          list_dist[0] <= cand_dist;
          list_idx[0]  <= cand_idx;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_ins) begin
          if (g[i-1]) begin
            list_dist[i] <= list_dist[i-1];
            list_idx[i]  <= list_idx[i-1];
          end else if ((ins_pos == KW'(i)) || g[i]) begin
            list_dist[i] <= cand_dist;
            list_idx[i]  <= cand_idx;
          end
        end
      end
    end
  end

  assign do_ins    = cand_valid && cand_ins && (held_lt_k || |(gt & below_held));
  assign emit_last = (KW'(emit_pos) + KW'(1)) == emit_cnt;
  assign out_load  = emitting && (emit_cnt != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      emitting  <= 1'b0;
      emit_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_ins && held_lt_k) begin
        held <= held + KW'(1);
      end
      if (cand_valid && cand_last) begin
        emitting <= 1'b1;
        emit_pos <= '0;
      end else if (emitting && (emit_cnt == '0)) begin
        emitting <= 1'b0;
        held     <= '0;
      end else if (out_load) begin
        if (emit_last) begin
          emitting <= 1'b0;
          held     <= '0;
        end else begin
          emit_pos <= emit_pos + EW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_valid && cand_last) begin
      emit_ovf <= cand_ovf;
    end
    if (out_load) begin
      neighbor_index <= INDEX_W'(list_idx[emit_pos]);
      distance       <= list_dist[emit_pos];
      last_result    <= emit_last;
      overflow       <= emit_ovf;
    end
  end

endmodule

/* src/knn_topk_l2_search_core.sv */
// Output: the last base item passes front stages a and b, the queue and the candidate register
// before reporting starts, then one result per cycle while out_ready is high.
// Throughput: one item per cycle; reporting stops the back end popping until its last result
// is loaded, and in_ready drops once the front stages and 4-entry queue hold four items.
// Reset: synchronous, active high; clears counters, the queue and sets k_count 1, dim 128;
// the query store and the neighbor list hold until written.
module knn_topk_l2_search_core #(
  parameter int K_MAX          = 16,
  parameter int DIM_MAX        = 1024,
  parameter int BASE_MAX       = 1048576,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [knn_pkg::APB_AW-1:0]        paddr,
  input  logic [knn_pkg::APB_DW-1:0]        pwdata,
  output logic [knn_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic signed [knn_pkg::COMP_W-1:0] component,
  input  logic                              last_in_set,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [knn_pkg::INDEX_W-1:0]       neighbor_index,
  output logic [knn_pkg::DIST_W-1:0]        distance,
  output logic                              last_result,
  output logic                              overflow
);

  import knn_pkg::*;

  localparam int QW = 2*COMPONENT_BITS + $bits(knn_flags_t);

  knn_cfg_t                    cfg;
  logic                        push;
  logic [2*COMPONENT_BITS-1:0] push_sq;
  knn_flags_t                  push_flags;
  logic [QW-1:0]               q_rdata;
  logic                        q_empty;
  logic [QCNT_W-1:0]           q_count;
  logic                        pop;
  logic [2*COMPONENT_BITS-1:0] q_sq;
  knn_flags_t                  q_flags;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.k_count <= K_COUNT_RESET;
      cfg.dim     <= DIM_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_K_COUNT: cfg.k_count <= K_COUNT_W'(pwdata);
        REG_DIM:     cfg.dim     <= DIM_W'(pwdata);
        default:     cfg         <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_K_COUNT: prdata = APB_DW'(cfg.k_count);
      REG_DIM:     prdata = APB_DW'(cfg.dim);
      default:     prdata = '0;
    endcase
  end

  knn_front #(
    .DIM_MAX        (DIM_MAX),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .component   (component),
    .last_in_set (last_in_set),
    .queue_count (q_count),
    .push        (push),
    .push_sq     (push_sq),
    .push_flags  (push_flags)
  );

  knn_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_sq, push_flags}),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  assign q_sq    = q_rdata[QW-1 -: 2*COMPONENT_BITS];
  assign q_flags = q_rdata[$bits(knn_flags_t)-1:0];

  knn_back #(
    .K_MAX          (K_MAX),
    .BASE_MAX       (BASE_MAX),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_sq           (q_sq),
    .q_flags        (q_flags),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .neighbor_index (neighbor_index),
    .distance       (distance),
    .last_result    (last_result),
    .overflow       (overflow)
  );

endmodule

/* src/knn_checker.sv */
module knn_checker #(
  parameter int K_MAX = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [knn_pkg::INDEX_W-1:0]  neighbor_index,
  input logic [knn_pkg::DIST_W-1:0]   distance,
  input logic                         last_result,
  input logic                         overflow
);

  import knn_pkg::*;

  localparam int NW = $clog2(K_MAX + 1);

  logic               open;
  logic [DIST_W-1:0]  prev_dist;
  logic [INDEX_W-1:0] prev_index;
  logic               prev_ovf;
  logic [NW-1:0]      nres;

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      nres <= '0;
    end else if (out_valid && out_ready) begin
      if (last_result) begin
        open <= 1'b0;
        nres <= '0;
      end else begin
        open <= 1'b1;
        nres <= nres + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_dist  <= distance;
      prev_index <= neighbor_index;
      prev_ovf   <= overflow;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) &&
      $stable(neighbor_index) && $stable(last_result))
    else $error("result changed while stalled");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    out_valid && open |-> (distance > prev_dist) ||
      ((distance == prev_dist) && (neighbor_index > prev_index)))
    else $error("results out of order");

  a_ovf_const: assert property (@(posedge clk) disable iff (rst)
    out_valid && open |-> overflow == prev_ovf)
    else $error("overflow flag changed within one query");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nres < NW'(K_MAX))
    else $error("too many results for one query");

endmodule

bind knn_topk_l2_search_core knn_checker #(
  .K_MAX (K_MAX)
) u_knn_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .neighbor_index (neighbor_index),
  .distance       (distance),
  .last_result    (last_result),
  .overflow       (overflow)
);
